// ----- design/ffba_pkg.sv -----
// Shared types and constants for the first-fit bank allocator.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

  // Defaults for the top-level parameters
  localparam int DefBankCount = 128;
  localparam int DefBankBytes = 64;

  // Fixed field widths
  localparam int ReqW  = 32;
  localparam int AddrW = 16;
  localparam int FillW = 7;
  localparam int SizeW = 14;
  localparam int PosW  = 8;

  localparam logic [AddrW-1:0] HeapBaseReset = 16'hB700;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } ffba_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;      // request beat accepted: load request, clear scan
    logic scan_step;  // examine one bank
    logic fill_step;  // claim one bank and write its metadata
    logic load_out;   // move the answer into the output register
  } ffba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic too_big;    // request on the input exceeds the whole heap
    logic hit;        // the bank under the scan completes a long enough run
    logic scan_end;   // the scan is on the last bank
    logic fill_last;  // the bank being filled closes the run
    logic out_free;   // output register can take a new beat
  } ffba_status_t;

endpackage

// ----- design/ffba_ctrl.sv -----
// Controller state machine for the first-fit bank allocator.
// Depends on ffba_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  ffba_status_t status,
  output ffba_cmd_t    cmd
);

  ffba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.too_big ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status.hit) begin
          state_nxt = ST_FILL;
        end else if (status.scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        if (status.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_FILL: cmd.fill_step = 1'b1;
      ST_DONE: cmd.load_out  = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- design/ffba_datapath.sv -----
// Datapath for the first-fit bank allocator: occupancy bits, scan and fill
// registers, bank metadata memories, base register and output register.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int BANK_COUNT = DefBankCount,
  parameter int BANK_BYTES = DefBankBytes
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ReqW-1:0]  in_request_bytes,
  input  logic             cfg_wr_en,
  input  logic [AddrW-1:0] cfg_wr_data,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [AddrW-1:0] out_block_address,
  output logic             out_alloc_ok,
  input  ffba_cmd_t        cmd,
  output ffba_status_t     status
);

  localparam int HeapBytes = BANK_COUNT * BANK_BYTES;
  localparam int IdxW      = $clog2(BANK_COUNT);
  localparam int BytesW    = $clog2(HeapBytes + 1);

  logic [BANK_COUNT-1:0] bank_used_r;
  logic [FillW-1:0]      bank_fill_mem [BANK_COUNT];
  logic [SizeW-1:0]      size_mem      [BANK_COUNT];
  logic [PosW-1:0]       pos_mem       [BANK_COUNT];

  logic [AddrW-1:0]  heap_base_r;
  logic [BytesW-1:0] req_r;       // request size, known to fit the heap
  logic [IdxW-1:0]   idx_r;       // bank under scan or fill
  logic [IdxW-1:0]   start_r;     // first bank of the candidate run
  logic [BytesW-1:0] run_bytes_r; // bytes covered by the candidate run
  logic [BytesW-1:0] rem_r;       // bytes still to place during fill
  logic [PosW-1:0]   pos_r;
  logic              single_r;    // request fits one bank
  logic              ok_r;

  logic              out_valid_r;
  logic [AddrW-1:0]  out_addr_r;
  logic              out_ok_r;

  logic              cur_used;
  logic [BytesW-1:0] run_sum;
  logic              hit;
  logic              fill_last;
  logic [BytesW-1:0] fill_bytes;
  logic [AddrW-1:0]  offset;

  assign cur_used   = bank_used_r[idx_r];
  assign run_sum    = run_bytes_r + BytesW'(BANK_BYTES);
  assign hit        = !cur_used && (run_sum >= req_r);
  assign fill_last  = rem_r <= BytesW'(BANK_BYTES);
  assign fill_bytes = fill_last ? rem_r : BytesW'(BANK_BYTES);
  assign offset     = AddrW'(32'(start_r) * 32'(BANK_BYTES));

  assign status.too_big   = in_request_bytes > ReqW'(HeapBytes);
  assign status.hit       = hit;
  assign status.scan_end  = idx_r == IdxW'(BANK_COUNT - 1);
  assign status.fill_last = fill_last;
  assign status.out_free  = !out_valid_r || !out_stall;

  // Base register and occupancy bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= HeapBaseReset;
      bank_used_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        heap_base_r <= cfg_wr_data;
      end
      if (cmd.fill_step) begin
        bank_used_r[idx_r] <= 1'b1;
      end
    end
  end

  // Metadata memories, write only
  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      bank_fill_mem[idx_r] <= fill_bytes[FillW-1:0];
      size_mem[idx_r]      <= req_r[SizeW-1:0];
      pos_mem[idx_r]       <= single_r ? '0 : pos_r;
    end
  end

  // Scan and fill registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (cmd.start) begin
      ok_r <= 1'b0;
    end else if (cmd.scan_step && hit) begin
      ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r       <= in_request_bytes[BytesW-1:0];
      single_r    <= in_request_bytes <= ReqW'(BANK_BYTES);
      idx_r       <= '0;
      start_r     <= '0;
      run_bytes_r <= '0;
    end else if (cmd.scan_step) begin
      priority if (hit) begin
        idx_r <= start_r;
        rem_r <= req_r;
        pos_r <= PosW'(1);
      end else if (cur_used) begin
        run_bytes_r <= '0;
        start_r     <= idx_r + IdxW'(1);
        idx_r       <= idx_r + IdxW'(1);
      end else begin
        run_bytes_r <= run_sum;
        idx_r       <= idx_r + IdxW'(1);
      end
    end else if (cmd.fill_step) begin
      idx_r <= idx_r + IdxW'(1);
      rem_r <= rem_r - BytesW'(BANK_BYTES);
      pos_r <= pos_r + PosW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok_r   <= ok_r;
      out_addr_r <= ok_r ? heap_base_r + offset : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_alloc_ok      = out_ok_r;

endmodule

// ----- design/first_fit_bank_allocator.sv -----
// First-fit bank allocator, top level: controller plus datapath.
// A request beat is taken in IDLE; the bank-by-bank scan then looks for a long enough free
// run, the fill claims its banks and the result is loaded. A request larger than the heap skips
// the scan and fill. One request at a time: the input stalls until the result is loaded;
// the output register then frees the input side while the result beat waits.
// Reset (rst_n low, synchronous): all banks free, base 0xB700, no beat pending.
`timescale 1ns / 1ps

module first_fit_bank_allocator
  import ffba_pkg::*;
#(
  parameter int BANK_COUNT = DefBankCount,
  parameter int BANK_BYTES = DefBankBytes
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ReqW-1:0]  in_request_bytes,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [AddrW-1:0] out_block_address,
  output logic             out_alloc_ok,
  input  logic             cfg_wr_en,
  input  logic [AddrW-1:0] cfg_wr_data
);

  // The controller walks IDLE -> SCAN -> FILL -> DONE. A request larger than
  // the heap skips straight to DONE; a scan that reaches the last bank without
  // a long enough run also lands in DONE with the fail flag.
  ffba_cmd_t    cmd;
  ffba_status_t status;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds one occupancy bit per bank; the scan reads one bank per
  // cycle and the fill claims one bank per cycle, writing its fill, the
  // request size and its run position.
  ffba_datapath #(
    .BANK_COUNT (BANK_COUNT),
    .BANK_BYTES (BANK_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_request_bytes  (in_request_bytes),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_block_address (out_block_address),
    .out_alloc_ok      (out_alloc_ok),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

// ----- design/ffba_checker.sv -----
// Port-level checks for the first-fit bank allocator, bound to the top level.
// Depends on ffba_pkg for field widths.
`timescale 1ns / 1ps

module ffba_checker
  import ffba_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [ReqW-1:0]  in_request_bytes,
  input logic             out_valid,
  input logic             out_stall,
  input logic [AddrW-1:0] out_block_address,
  input logic             out_alloc_ok
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_block_address)
      && $stable(out_alloc_ok))
    else $error("stalled result beat changed or dropped");

  // Hold a stalled request beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_request_bytes))
    else $error("stalled request beat changed or dropped");

  // Failed allocation reports address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_alloc_ok |-> out_block_address == '0)
    else $error("failed allocation with nonzero address");

  // Busy the cycle after a request beat is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken back to back");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind first_fit_bank_allocator ffba_checker u_ffba_checker (.*);
